[src/prce_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prce_pkg: shared types and constants of the raster command engine
// Screen, font and colormap geometry, bus access decode and the
// controller to datapath command and status structs.
// ----------------------------------------------------------------------------
package prce_pkg;

  localparam int SCREEN_WIDTH  = 1024;
  localparam int SCREEN_HEIGHT = 768;
  localparam int FONT_DEPTH    = 65536;
  localparam int MAP_COUNT     = 16;

  localparam int XW        = $clog2(SCREEN_WIDTH);
  localparam int YW        = $clog2(SCREEN_HEIGHT);
  localparam int PIX_DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int PIX_AW    = $clog2(PIX_DEPTH);
  localparam int FONT_AW   = $clog2(FONT_DEPTH);
  localparam int CT_DEPTH  = 16 * 4 * 256;
  localparam int CT_AW     = $clog2(CT_DEPTH);
  localparam int CLR_LEN   = PIX_DEPTH;
  localparam int CLR_W     = $clog2(CLR_LEN);
  localparam int CW        = 17;  // signed coordinate width

  // buffer file entries
  localparam logic [4:0] BF_XS = 5'd3;
  localparam logic [4:0] BF_XE = 5'd4;
  localparam logic [4:0] BF_YS = 5'd5;
  localparam logic [4:0] BF_YE = 5'd6;
  localparam logic [4:0] BF_FA = 5'd7;

  // bus window offsets
  localparam logic [11:0] OFS_CTRL     = 12'h180;
  localparam logic [11:0] OFS_BUF_LO   = 12'h080;
  localparam logic [11:0] OFS_BUF_HI   = 12'h0c0;
  localparam logic [11:0] OFS_CMD      = 12'h200;
  localparam logic [12:0] OFS_CMAP_LO  = 13'h0200;
  localparam logic [12:0] OFS_CMAP_HI  = 13'h0800;
  localparam logic [12:0] OFS_FLAGS_HI = 13'h0002;

  // command codes
  localparam logic [10:0] CMD_CLO   = 11'h15;
  localparam logic [10:0] CMD_CHI   = 11'h14;
  localparam logic [10:0] CMD_ELO   = 11'h17;
  localparam logic [10:0] CMD_EHI   = 11'h16;
  localparam logic [10:0] CMD_FPTR  = 11'h03;
  localparam logic [10:0] CMD_FWR   = 11'h01;
  localparam logic [10:0] CMD_FILL  = 11'h0a;
  localparam logic [10:0] CMD_GLYPH = 11'h09;
  localparam logic [10:0] CMD_PLO   = 11'h1b;
  localparam logic [10:0] CMD_PHI   = 11'h1a;
  localparam logic [10:0] CMD_RPIXA = 11'h19;
  localparam logic [10:0] CMD_RPIXB = 11'h18;
  localparam logic [10:0] CMD_RFONT = 11'h00;

  typedef enum logic [4:0] {
    OP_NONE, OP_RD_LATCH, OP_RD_CTRL, OP_RD_PIX, OP_RD_FONT, OP_RD_CMAP,
    OP_RD_FLAGS, OP_WR_LATCH, OP_WR_CTRL, OP_WR_BUF, OP_WR_FLAGS,
    OP_WR_CMAP, OP_CLO, OP_CHI, OP_ELO, OP_EHI, OP_FPTR, OP_FWR,
    OP_FILL, OP_GLYPH, OP_PLO, OP_PHI
  } op_e;

  typedef struct packed {
    logic clr;
    logic acc;
    logic exec;
    logic resp;
    logic wk_rd;
    logic wk_wr;
    op_e  op;
  } ctl_t;

  typedef struct packed {
    logic clr_done;
    logic fill_empty;
    logic wk_last;
  } stat_t;

  function automatic op_e decode(input logic wr, input logic [13:0] offs);
    logic [11:0] o1;
    logic [12:0] o2;
    logic [10:0] code;
    op_e         op;
    o1   = offs[11:0];
    o2   = offs[12:0];
    code = o1[11:1] - OFS_CMD[11:1];
    op   = OP_NONE;
    if (offs[13:12] == 2'd0) begin
      if (offs[11:10] == 2'd2) op = wr ? OP_WR_LATCH : OP_RD_LATCH;
    end else if (offs[13:12] == 2'd1) begin
      if (o1 == OFS_CTRL) begin
        op = wr ? OP_WR_CTRL : OP_RD_CTRL;
      end else if (wr && o1 >= OFS_BUF_LO && o1 < OFS_BUF_HI) begin
        op = OP_WR_BUF;
      end else if (o1 >= OFS_CMD) begin
        if (wr) begin
          case (code)
            CMD_CLO:   op = OP_CLO;
            CMD_CHI:   op = OP_CHI;
            CMD_ELO:   op = OP_ELO;
            CMD_EHI:   op = OP_EHI;
            CMD_FPTR:  op = OP_FPTR;
            CMD_FWR:   op = OP_FWR;
            CMD_FILL:  op = OP_FILL;
            CMD_GLYPH: op = OP_GLYPH;
            CMD_PLO:   op = OP_PLO;
            CMD_PHI:   op = OP_PHI;
            default:   op = OP_NONE;
          endcase
        end else begin
          case (code)
            CMD_RPIXA, CMD_RPIXB: op = OP_RD_PIX;
            CMD_RFONT:            op = OP_RD_FONT;
            default:              op = OP_NONE;
          endcase
        end
      end
    end else begin
      if (wr) begin
        if (o2 < OFS_FLAGS_HI) op = OP_WR_FLAGS;
        else if (o2 >= OFS_CMAP_LO && o2 < OFS_CMAP_HI) op = OP_WR_CMAP;
      end else begin
        op = (o2 >= OFS_CMAP_LO && o2 < OFS_CMAP_HI) ? OP_RD_CMAP : OP_RD_FLAGS;
      end
    end
    return op;
  endfunction

endpackage

[src/prce_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prce_ctrl: sequencing controller
// Runs the clearing pass, accepts bus transactions, steps the datapath
// through execute, pixel walk and response, and holds the output valid.
// ----------------------------------------------------------------------------
module prce_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 func_i,
  input  logic [13:0]          bus_offset_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  prce_pkg::stat_t      stat_i,
  output prce_pkg::ctl_t       ctl_o
);
  import prce_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_EXEC, ST_RESP, ST_WK_RD, ST_WK_WR
  } state_e;

  state_e state_q;
  op_e    op_q;
  logic   out_valid_q;
  logic   accept;
  logic   resp_go;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  // the response waits until the output register is free
  assign resp_go     = (state_q == ST_RESP) && (!out_valid_q || out_ready_i);

  always_comb begin
    ctl_o       = '0;
    ctl_o.clr   = (state_q == ST_CLEAR);
    ctl_o.acc   = accept;
    ctl_o.exec  = (state_q == ST_EXEC);
    ctl_o.resp  = resp_go;
    ctl_o.wk_rd = (state_q == ST_WK_RD);
    ctl_o.wk_wr = (state_q == ST_WK_WR);
    ctl_o.op    = op_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      op_q        <= OP_NONE;
      out_valid_q <= 1'b0;
    end else begin
      if (resp_go) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: begin
          if (stat_i.clr_done) state_q <= ST_IDLE;
        end
        ST_IDLE: begin
          if (accept) begin
            op_q    <= decode(func_i, bus_offset_i);
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (op_q == OP_GLYPH || (op_q == OP_FILL && !stat_i.fill_empty)) begin
            state_q <= ST_WK_RD;
          end else begin
            state_q <= ST_RESP;
          end
        end
        ST_WK_RD: state_q <= ST_WK_WR;
        ST_WK_WR: begin
          state_q <= stat_i.wk_last ? ST_RESP : ST_WK_RD;
        end
        ST_RESP: begin
          if (resp_go) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

[src/prce_dpath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prce_dpath: registers, stores and pixel walker
// Holds the pixel, font and colormap stores, the buffer file and the
// control registers, and walks fill and glyph pixels read-modify-write.
// ----------------------------------------------------------------------------
module prce_dpath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  prce_pkg::ctl_t    ctl_i,
  output prce_pkg::stat_t   stat_o,
  input  logic [13:0]       bus_offset_i,
  input  logic [15:0]       write_data_i,
  output logic [15:0]       read_data_o
);
  import prce_pkg::*;

  function automatic logic [3:0] plane_mix(input logic [3:0] p, input logic [1:0] c,
                                           input logic [1:0] e, input logic hi);
    logic [3:0] m;
    logic [3:0] cv;
    m  = hi ? {e, 2'b00} : {2'b00, e};
    cv = hi ? {c, 2'b00} : {2'b00, c};
    return (p & ~m) | (cv & m);
  endfunction

  function automatic logic on_screen(input logic signed [CW-1:0] x,
                                     input logic signed [CW-1:0] y);
    return !x[CW-1] && (x < CW'(SCREEN_WIDTH)) && !y[CW-1] && (y < CW'(SCREEN_HEIGHT));
  endfunction

  function automatic logic [PIX_AW-1:0] pix_addr(input logic signed [CW-1:0] x,
                                                 input logic signed [CW-1:0] y);
    return PIX_AW'(y[YW-1:0]) * PIX_AW'(SCREEN_WIDTH) + PIX_AW'(x[XW-1:0]);
  endfunction

  // stores
  logic [3:0]  pix_mem  [PIX_DEPTH];
  logic [15:0] font_mem [FONT_DEPTH];
  logic [7:0]  ct_mem   [CT_DEPTH];

  logic [15:0] buf_q [32];
  logic [1:0]  clo_q, chi_q, elo_q, ehi_q;
  logic [15:0] ctrl_q, fptr_q, latch_q, flags_q;
  logic [15:0] wd_q;
  logic [13:0] offs_q;
  logic [CLR_W-1:0] clr_cnt_q;

  logic signed [CW-1:0] wx_q, wy_q;
  logic [2:0] gc_q;
  logic [3:0] gr_q;

  logic [3:0]  pix_rd_q;
  logic [15:0] font_rd_q;
  logic [7:0]  ct_rd_q;
  logic [15:0] read_data_q;

  logic signed [CW-1:0] xs, xe, ys, ye, x0, x1, y0, y1;
  logic        st_on, wk_on, map_ok, glyph_bit;
  logic [3:0]  map;
  logic [1:0]  chan;
  logic [CT_AW-1:0] ct_addr, ct_clr_map;

  assign xs = {buf_q[BF_XS][15], buf_q[BF_XS]};
  assign xe = {buf_q[BF_XE][15], buf_q[BF_XE]};
  assign ys = {buf_q[BF_YS][15], buf_q[BF_YS]};
  assign ye = {buf_q[BF_YE][15], buf_q[BF_YE]};
  assign x0 = xs[CW-1] ? '0 : xs;
  assign y0 = ys[CW-1] ? '0 : ys;
  assign x1 = (xe > CW'(SCREEN_WIDTH - 1))  ? CW'(SCREEN_WIDTH - 1)  : xe;
  assign y1 = (ye > CW'(SCREEN_HEIGHT - 1)) ? CW'(SCREEN_HEIGHT - 1) : ye;

  assign st_on     = on_screen(xs, ys);
  assign wk_on     = on_screen(wx_q, wy_q);
  assign map       = flags_q[3:0];
  assign map_ok    = {1'b0, map} < 5'(MAP_COUNT);
  assign chan      = offs_q[10:9] - 2'd1;
  assign ct_addr   = {map, chan, offs_q[8:1]};
  assign ct_clr_map = clr_cnt_q[CT_AW-1:0];
  assign glyph_bit = font_rd_q[4'(4'd15 - {1'b0, gc_q})];

  assign stat_o.clr_done   = (clr_cnt_q == CLR_W'(CLR_LEN - 1));
  assign stat_o.fill_empty = (x0 > x1) || (y0 > y1);
  assign stat_o.wk_last    = (ctl_i.op == OP_GLYPH) ? (gc_q == 3'd7 && gr_q == 4'd15)
                                                    : (wx_q == x1 && wy_q == y1);

  // pixel store port control
  logic             pix_we, pix_re;
  logic [PIX_AW-1:0] pix_wa, pix_ra;
  logic [3:0]       pix_wd;

  always_comb begin
    pix_we = 1'b0;
    pix_wa = pix_addr(wx_q, wy_q);
    pix_wd = plane_mix(plane_mix(pix_rd_q, clo_q, elo_q, 1'b0), chi_q, ehi_q, 1'b1);
    if (ctl_i.clr) begin
      pix_we = 1'b1;
      pix_wa = PIX_AW'(clr_cnt_q);
      pix_wd = '0;
    end else if (ctl_i.resp && (ctl_i.op == OP_PLO || ctl_i.op == OP_PHI)) begin
      pix_we = st_on;
      pix_wa = pix_addr(xs, ys);
      pix_wd = (ctl_i.op == OP_PHI) ? plane_mix(pix_rd_q, chi_q, ehi_q, 1'b1)
                                    : plane_mix(pix_rd_q, clo_q, elo_q, 1'b0);
    end else if (ctl_i.wk_wr) begin
      pix_we = wk_on && (ctl_i.op == OP_FILL || glyph_bit);
    end
    pix_re = ctl_i.exec || ctl_i.wk_rd;
    pix_ra = ctl_i.exec ? pix_addr(xs, ys) : pix_addr(wx_q, wy_q);
  end

  always_ff @(posedge clk_i) begin
    if (pix_we) pix_mem[pix_wa] <= pix_wd;
    if (pix_re) pix_rd_q <= pix_mem[pix_ra];
  end

  // font store
  logic              font_we;
  logic [FONT_AW-1:0] font_wa, font_ra;
  logic [15:0]       font_wd;

  always_comb begin
    font_we = ctl_i.exec && ctl_i.op == OP_FWR;
    font_wa = fptr_q[FONT_AW-1:0];
    font_wd = wd_q;
    if (ctl_i.clr) begin
      font_we = clr_cnt_q < CLR_W'(FONT_DEPTH);
      font_wa = clr_cnt_q[FONT_AW-1:0];
      font_wd = '0;
    end
    font_ra = ctl_i.exec ? fptr_q[FONT_AW-1:0]
                         : FONT_AW'(buf_q[BF_FA] + {12'd0, gr_q});
  end

  always_ff @(posedge clk_i) begin
    if (font_we) font_mem[font_wa] <= font_wd;
    if (ctl_i.exec || ctl_i.wk_rd) font_rd_q <= font_mem[font_ra];
  end

  // colormap store, map zero cleared to ramps
  logic             ct_we;
  logic [CT_AW-1:0] ct_wa;
  logic [7:0]       ct_wd, ramp_e;

  always_comb begin
    ramp_e = ct_clr_map[7:0];
    ct_we  = ctl_i.exec && ctl_i.op == OP_WR_CMAP && map_ok;
    ct_wa  = ct_addr;
    ct_wd  = wd_q[7:0];
    if (ctl_i.clr) begin
      ct_we = clr_cnt_q < CLR_W'(CT_DEPTH);
      ct_wa = ct_clr_map;
      ct_wd = '0;
      if (ct_clr_map[CT_AW-1:10] == '0) begin
        case (ct_clr_map[9:8])
          2'd0:    ct_wd = ramp_e;
          2'd1:    ct_wd = 8'(ramp_e * 8'd3);
          2'd2:    ct_wd = 8'(ramp_e * 8'd7);
          default: ct_wd = '0;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ct_we) ct_mem[ct_wa] <= ct_wd;
    if (ctl_i.exec) ct_rd_q <= ct_mem[ct_addr];
  end

  // payload capture and pixel walker
  always_ff @(posedge clk_i) begin
    if (ctl_i.acc) begin
      wd_q   <= write_data_i;
      offs_q <= bus_offset_i;
    end
    if (ctl_i.exec) begin
      wx_q <= (ctl_i.op == OP_FILL) ? x0 : xs;
      wy_q <= (ctl_i.op == OP_FILL) ? y0 : ys;
      gc_q <= '0;
      gr_q <= '0;
    end else if (ctl_i.wk_wr) begin
      if (ctl_i.op == OP_FILL) begin
        if (wx_q == x1) begin
          wx_q <= x0;
          wy_q <= wy_q + CW'(1);
        end else begin
          wx_q <= wx_q + CW'(1);
        end
      end else begin
        if (gc_q == 3'd7) begin
          gc_q <= '0;
          gr_q <= gr_q + 4'd1;
          wx_q <= xs;
          wy_q <= wy_q + CW'(1);
        end else begin
          gc_q <= gc_q + 3'd1;
          wx_q <= wx_q + CW'(1);
        end
      end
    end
    if (ctl_i.resp) begin
      case (ctl_i.op)
        OP_RD_LATCH: read_data_q <= latch_q;
        OP_RD_CTRL:  read_data_q <= {1'b0, ctrl_q[14:0]};
        OP_RD_PIX:   read_data_q <= st_on ? {12'd0, pix_rd_q} : '0;
        OP_RD_FONT:  read_data_q <= font_rd_q;
        OP_RD_CMAP:  read_data_q <= map_ok ? {8'd0, ct_rd_q} : '0;
        OP_RD_FLAGS: read_data_q <= flags_q;
        default:     read_data_q <= '0;
      endcase
    end
  end

  assign read_data_o = read_data_q;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 32; i++) buf_q[i] <= '0;
      clo_q     <= '0;
      chi_q     <= '0;
      elo_q     <= '0;
      ehi_q     <= '0;
      ctrl_q    <= '0;
      fptr_q    <= '0;
      latch_q   <= '0;
      flags_q   <= '0;
      clr_cnt_q <= '0;
    end else begin
      if (ctl_i.clr && !stat_o.clr_done) clr_cnt_q <= clr_cnt_q + 1'b1;
      if (ctl_i.exec) begin
        case (ctl_i.op)
          OP_WR_LATCH: latch_q <= wd_q;
          OP_WR_CTRL:  ctrl_q  <= wd_q;
          OP_WR_BUF:   buf_q[offs_q[5:1]] <= wd_q;
          OP_WR_FLAGS: flags_q <= wd_q;
          OP_CLO:      clo_q   <= wd_q[1:0];
          OP_CHI:      chi_q   <= wd_q[1:0];
          OP_ELO:      elo_q   <= wd_q[1:0];
          OP_EHI:      ehi_q   <= wd_q[1:0];
          OP_FPTR:     fptr_q  <= 16'(buf_q[BF_FA][FONT_AW-1:0]);
          OP_FWR:      fptr_q  <= fptr_q + 16'd1;
          default: ;
        endcase
      end
    end
  end

endmodule

[src/plane_raster_command_engine_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plane_raster_command_engine_top: raster command engine
// One 16-bit bus read or write per transaction; writes load registers,
// the buffer file and the colormap, or run drawing commands.
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid_i / in_ready_o with func_i (1 = write),
//   bus_offset_i and write_data_i; one transaction per bus access
//   output channel: out_valid_o / out_ready_i with read_data_o, one
//   result per input transaction, zero for writes
//   steps: a register or single-pixel access passes from acceptance
//   through execute and the response into the output register; a fill
//   walks each clipped pixel and a glyph its 8 by 16 pixels, with a
//   read step and then a write step per pixel on the pixel store
//   transactions: one transaction
//   is in flight at a time and the next is taken while the last result
//   still sits in the output register
//   when the receiver stalls, the result is held and after one more
//   transaction is executed, input stays blocked
//   reset: a clearing pass zeroes the pixel and font stores and the
//   colormap but writes the ramps of colormap zero, with in_ready_o low
// ----------------------------------------------------------------------------
module plane_raster_command_engine_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        func_i,
  input  logic [13:0] bus_offset_i,
  input  logic [15:0] write_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] read_data_o
);
  import prce_pkg::*;

  ctl_t  ctl;
  stat_t stat;

  // sequencing, handshakes and the clearing pass
  prce_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .func_i       (func_i),
    .bus_offset_i (bus_offset_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .stat_i       (stat),
    .ctl_o        (ctl)
  );

  // stores, registers, pixel walker and the result register
  prce_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .stat_o       (stat),
    .bus_offset_i (bus_offset_i),
    .write_data_i (write_data_i),
    .read_data_o  (read_data_o)
  );

endmodule

[tb/plane_raster_command_engine_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plane_raster_command_engine_top_tb: self-checking bench of the raster engine
// Drives bus reads and writes with random idle gaps on both channels and
// tracks the pixel, font, colormap and register state in its own predictor;
// each result is checked in order against the predicted read data.
// ----------------------------------------------------------------------------
module plane_raster_command_engine_top_tb;
  import prce_pkg::*;

  localparam int          CYCLE_LIMIT = 6_000_000;
  localparam logic [13:0] ADR_LATCH   = 14'h0800;
  localparam logic [13:0] ADR_CTRL    = 14'h1180;
  localparam logic [13:0] ADR_BUF     = 14'h1080;
  localparam logic [13:0] ADR_CMD     = 14'h1200;
  localparam logic [13:0] ADR_FLAGS   = 14'h2000;
  localparam logic [13:0] ADR_CMAP    = 14'h2200;

  typedef struct {
    logic        wr;
    logic [13:0] offs;
    logic [15:0] wd;
  } bus_access_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready_o;
  logic        func = 1'b0;
  logic [13:0] bus_offset = '0;
  logic [15:0] write_data = '0;
  logic        out_valid_o;
  logic        out_ready = 1'b0;
  logic [15:0] read_data_o;

  plane_raster_command_engine_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready_o),
    .func_i       (func),
    .bus_offset_i (bus_offset),
    .write_data_i (write_data),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready),
    .read_data_o  (read_data_o)
  );

  // predicted engine state
  logic [3:0]  pix_mem  [PIX_DEPTH];
  logic [15:0] font_mem [FONT_DEPTH];
  logic [7:0]  cmap_mem [MAP_COUNT][256][3];
  logic [15:0] buf_mem  [32];
  logic [1:0]  colour_lo, colour_hi, enable_lo, enable_hi;
  logic [15:0] ctrl_word, font_ptr, data_latch, disp_flags;

  bus_access_t bus_access_q[$];
  logic [15:0] read_data_exp_q[$];
  bus_access_t next_access;
  int          errors = 0;
  int          cycles = 0;
  int          send_gap = 0;
  int          stall_left = 0;
  bit          send_calm = 0;
  bit          recv_calm = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- predictor
  function automatic int coord_of(int e);
    return int'($signed(buf_mem[e]));
  endfunction

  function automatic logic [3:0] plane_blend(logic [3:0] prev, logic [1:0] colour,
                                             logic [1:0] en, int sh);
    logic [3:0] m;
    m = 4'(en) << sh;
    return (prev & ~m) | ((4'(colour) << sh) & m);
  endfunction

  function automatic bit visible(int x, int y);
    return x >= 0 && x < SCREEN_WIDTH && y >= 0 && y < SCREEN_HEIGHT;
  endfunction

  function automatic void paint_pixel(int x, int y, bit lo, bit hi);
    int i;
    if (!visible(x, y)) return;
    i = y * SCREEN_WIDTH + x;
    if (lo) pix_mem[i] = plane_blend(pix_mem[i], colour_lo, enable_lo, 0);
    if (hi) pix_mem[i] = plane_blend(pix_mem[i], colour_hi, enable_hi, 2);
  endfunction

  function automatic void run_command(logic [10:0] code, logic [15:0] wd);
    int x0, x1, y0, y1;
    logic [15:0] row;
    case (code)
      CMD_CLO:  colour_lo = wd[1:0];
      CMD_CHI:  colour_hi = wd[1:0];
      CMD_ELO:  enable_lo = wd[1:0];
      CMD_EHI:  enable_hi = wd[1:0];
      CMD_FPTR: font_ptr = buf_mem[BF_FA];
      CMD_FWR: begin
        font_mem[font_ptr] = wd;
        font_ptr = font_ptr + 16'd1;
      end
      CMD_FILL: begin
        // clip to the screen, empty when start passes end
        x0 = coord_of(BF_XS); x1 = coord_of(BF_XE);
        y0 = coord_of(BF_YS); y1 = coord_of(BF_YE);
        if (x0 < 0) x0 = 0;
        if (y0 < 0) y0 = 0;
        if (x1 > SCREEN_WIDTH - 1) x1 = SCREEN_WIDTH - 1;
        if (y1 > SCREEN_HEIGHT - 1) y1 = SCREEN_HEIGHT - 1;
        for (int y = y0; y <= y1; y++)
          for (int x = x0; x <= x1; x++) paint_pixel(x, y, 1, 1);
      end
      CMD_GLYPH: begin
        // rows wrap around the font store
        for (int r = 0; r < 16; r++) begin
          row = font_mem[16'(buf_mem[BF_FA] + r)];
          for (int c = 0; c < 8; c++)
            if (row[15-c]) paint_pixel(coord_of(BF_XS) + c, coord_of(BF_YS) + r, 1, 1);
        end
      end
      CMD_PLO: paint_pixel(coord_of(BF_XS), coord_of(BF_YS), 1, 0);
      CMD_PHI: paint_pixel(coord_of(BF_XS), coord_of(BF_YS), 0, 1);
      default: ;
    endcase
  endfunction

  // returns the read data that one bus transaction produces
  function automatic logic [15:0] raster_access(logic wr, logic [13:0] offs, logic [15:0] wd);
    int o, code, x, y;
    if (offs < 14'h1000) begin
      if (offs[11:10] != 2'd2) return '0;
      if (wr) data_latch = wd;
      return wr ? 16'h0 : data_latch;
    end
    if (offs < 14'h2000) begin
      o = int'(offs) - 'h1000;
      code = (o - 'h200) >> 1;
      if (o == 'h180) begin
        if (wr) ctrl_word = wd;
        return wr ? 16'h0 : {1'b0, ctrl_word[14:0]};
      end
      if (wr) begin
        if (o >= 'h80 && o < 'hc0) buf_mem[(o - 'h80) >> 1] = wd;
        else if (o >= 'h200) run_command(11'(code), wd);
        return '0;
      end
      if (o < 'h200) return '0;
      if (11'(code) == CMD_RPIXA || 11'(code) == CMD_RPIXB) begin
        x = coord_of(BF_XS);
        y = coord_of(BF_YS);
        return visible(x, y) ? 16'(pix_mem[y * SCREEN_WIDTH + x]) : 16'h0;
      end
      if (11'(code) == CMD_RFONT) return font_mem[font_ptr];
      return '0;
    end
    o = int'(offs) - 'h2000;
    if (o >= 'h200 && o < 'h800) begin
      // map select is four bits wide, so every map exists here
      if (wr) cmap_mem[disp_flags[3:0]][(o >> 1) & 'hff][((o >> 9) & 3) - 1] = wd[7:0];
      return wr ? 16'h0 : 16'(cmap_mem[disp_flags[3:0]][(o >> 1) & 'hff][((o >> 9) & 3) - 1]);
    end
    if (wr) begin
      if (o < 2) disp_flags = wd;
      return '0;
    end
    return disp_flags;
  endfunction

  // ---------------------------------------------------------------- stimulus
  task automatic put(logic wr, int offs, int wd);
    bus_access_t a;
    a.wr = wr;
    a.offs = 14'(offs);
    a.wd = 16'(wd);
    bus_access_q.push_back(a);
  endtask

  task automatic put_cmd(logic wr, logic [10:0] code, int wd);
    put(wr, int'(ADR_CMD) + 2 * int'(code) + $urandom_range(0, 1), wd);
  endtask

  task automatic put_buf(logic [4:0] e, int v);
    put(1'b1, int'(ADR_BUF) + 2 * int'(e) + $urandom_range(0, 1), v);
  endtask

  function automatic int pick_coord(int span, int edge_lo);
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(0, 40);
    if (r < 95) return edge_lo + $urandom_range(0, span);
    return -int'($urandom_range(1, 20));
  endfunction

  function automatic int pick_font_addr();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return $urandom_range(0, 63);
    if (r < 8) return $urandom_range(16'hfff0, 16'hffff);
    return $urandom_range(0, 16'hffff);
  endfunction

  task automatic draw_sequence();
    int x, y, kind, n;
    if ($urandom_range(0, 9) < 4) begin
      if ($urandom_range(0, 1)) put_cmd(1, CMD_CLO, $urandom);
      if ($urandom_range(0, 1)) put_cmd(1, CMD_CHI, $urandom);
      if ($urandom_range(0, 1)) put_cmd(1, CMD_ELO, $urandom);
      if ($urandom_range(0, 1)) put_cmd(1, CMD_EHI, $urandom);
    end
    x = pick_coord(30, 1000);
    y = pick_coord(40, 740);
    kind = $urandom_range(0, 3);
    put_buf(BF_XS, x);
    put_buf(BF_YS, y);
    case (kind)
      0: begin
        if ($urandom_range(0, 29) == 0) begin
          // far-off start clipped back onto the screen edge
          put_buf(BF_XS, -int'($urandom_range(1, 32768)));
          put_buf(BF_XE, $urandom_range(0, 6));
        end else begin
          put_buf(BF_XE, x + $urandom_range(0, 22) - 2);
        end
        put_buf(BF_YE, y + $urandom_range(0, 22) - 2);
        put_cmd(1, CMD_FILL, $urandom);
      end
      1: begin
        if ($urandom_range(0, 1)) put_buf(BF_FA, pick_font_addr());
        put_cmd(1, CMD_GLYPH, $urandom);
      end
      2: put_cmd(1, CMD_PLO, $urandom);
      default: put_cmd(1, CMD_PHI, $urandom);
    endcase
    n = $urandom_range(1, 3);
    repeat (n) begin
      put_buf(BF_XS, x + $urandom_range(0, 9));
      put_buf(BF_YS, y + $urandom_range(0, 17));
      put_cmd(0, $urandom_range(0, 1) ? CMD_RPIXA : CMD_RPIXB, $urandom);
    end
  endtask

  task automatic font_sequence();
    int n;
    put_buf(BF_FA, pick_font_addr());
    put_cmd(1, CMD_FPTR, $urandom);
    n = $urandom_range(1, 8);
    repeat (n) put_cmd(1, CMD_FWR, $urandom);
    put_cmd(0, CMD_RFONT, $urandom);
    put_cmd(1, CMD_FPTR, $urandom);
    put_cmd(0, CMD_RFONT, $urandom);
  endtask

  task automatic colormap_sequence();
    int o, n;
    put(1, int'(ADR_FLAGS) + $urandom_range(0, 1), $urandom);
    n = $urandom_range(1, 4);
    repeat (n) begin
      o = int'(ADR_CMAP) + $urandom_range(0, 'h5ff);
      put(1, o, $urandom);
      put(0, o, $urandom);
    end
    put(0, int'(ADR_CMAP) + $urandom_range(0, 'h5ff), $urandom);
  endtask

  task automatic noise_access();
    logic wr;
    int   offs;
    wr = $urandom_range(0, 1);
    offs = $urandom_range(0, 12287);
    // a fill from stray coordinates could cover the whole screen
    if (wr && offs >= 'h1200 && offs < 'h2000 && ((offs - 'h1200) >> 1) == int'(CMD_FILL))
      wr = 1'b0;
    put(wr, offs, $urandom);
  endtask

  task automatic build_stimulus();
    int r;
    // latch, control word and flags at their data extremes
    put(1, ADR_LATCH, 16'hffff);
    put(0, 14'h0bff, 0);
    put(0, 14'h0000, 0);
    put(1, ADR_CTRL, 16'hffff);
    put(0, ADR_CTRL, 0);
    put(1, 14'h2001, 16'h000f);
    put(1, ADR_CMAP, 16'habcd);
    put(0, ADR_CMAP, 0);
    put(0, 14'h2fff, 0);
    put(1, ADR_FLAGS, 16'h0000);
    put(0, 14'h27fe, 0);
    // all planes on, fill a box clipped at the lower left corner
    put_cmd(1, CMD_CLO, 16'hffff);
    put_cmd(1, CMD_CHI, 16'hffff);
    put_cmd(1, CMD_ELO, 16'hffff);
    put_cmd(1, CMD_EHI, 16'hffff);
    put_buf(BF_XS, 16'h8000);
    put_buf(BF_XE, 2);
    put_buf(BF_YS, 765);
    put_buf(BF_YE, 16'h7fff);
    put_cmd(1, CMD_FILL, 0);
    put_cmd(0, CMD_RPIXA, 0);
    // empty box: end before start
    put_buf(BF_XS, 10);
    put_buf(BF_XE, 5);
    put_cmd(1, CMD_FILL, 0);
    // last pixel of the screen through one pair
    put_buf(BF_XS, 1023);
    put_buf(BF_YS, 767);
    put_cmd(1, CMD_CHI, 1);
    put_cmd(1, CMD_PHI, 0);
    put_cmd(0, CMD_RPIXB, 0);
    // glyph whose rows wrap past the top of the font store
    put_buf(BF_FA, 16'hffff);
    put_cmd(1, CMD_FPTR, 0);
    put_cmd(1, CMD_FWR, 16'hffff);
    put_cmd(1, CMD_FWR, 16'h8001);
    put_buf(BF_XS, -3);
    put_buf(BF_YS, 0);
    put_cmd(1, CMD_GLYPH, 0);
    put_cmd(0, CMD_RFONT, 0);
    // scissor and unknown codes do nothing
    put_cmd(1, 11'h10, 16'hffff);
    put_cmd(0, 11'h11, 0);
    put(1, 14'h1fff, 16'hffff);

    while (bus_access_q.size() < 740) begin
      r = $urandom_range(0, 99);
      if (r < 40) draw_sequence();
      else if (r < 55) font_sequence();
      else if (r < 65) colormap_sequence();
      else noise_access();
    end
  endtask

  function automatic int idle_len(inout bit calm);
    int r;
    if ($urandom_range(0, 199) == 0) calm = !calm;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // ---------------------------------------------------------------- driver
  // predict on acceptance, then offer the next transaction after its gap
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready_o)
        read_data_exp_q.push_back(raster_access(func, bus_offset, write_data));
      if (!in_valid || in_ready_o) begin
        if (send_gap > 0 || bus_access_q.size() == 0) begin
          if (send_gap > 0) send_gap--;
          in_valid <= 1'b0;
        end else begin
          next_access = bus_access_q.pop_front();
          in_valid   <= 1'b1;
          func       <= next_access.wr;
          bus_offset <= next_access.offs;
          write_data <= next_access.wd;
          send_gap   = idle_len(send_calm);
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    errors++;
    $display("%0t: %s: read_data got %h expected %h", $time, what, got, want);
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) begin
        if (read_data_exp_q.size() == 0) begin
          report_mismatch("unexpected transaction", read_data_o, 16'h0);
        end else if (read_data_o !== read_data_exp_q[0]) begin
          report_mismatch("wrong result", read_data_o, read_data_exp_q.pop_front());
        end else begin
          void'(read_data_exp_q.pop_front());
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        stall_left = idle_len(recv_calm);
        out_ready <= (stall_left == 0);
      end
    end
  end

  // ---------------------------------------------------------------- timeout
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    colour_lo = '0; colour_hi = '0; enable_lo = '0; enable_hi = '0;
    ctrl_word = '0; font_ptr = '0; data_latch = '0; disp_flags = '0;
    foreach (pix_mem[i]) pix_mem[i] = '0;
    foreach (font_mem[i]) font_mem[i] = '0;
    foreach (buf_mem[i]) buf_mem[i] = '0;
    for (int m = 0; m < MAP_COUNT; m++)
      for (int i = 0; i < 256; i++)
        for (int c = 0; c < 3; c++) cmap_mem[m][i][c] = '0;
    // map zero starts as red, green and blue ramps
    for (int i = 0; i < 256; i++) begin
      cmap_mem[0][i][0] = 8'(i);
      cmap_mem[0][i][1] = 8'(i * 3);
      cmap_mem[0][i][2] = 8'(i * 7);
    end
    build_stimulus();

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // the clearing pass holds off input, then every transaction drains
    while (bus_access_q.size() != 0 || in_valid) @(posedge clk_i);
    while (read_data_exp_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
